// ----- design/rbm_free_energy_macros.svh -----
// rbm_free_energy_macros.svh: assertion macros for the free-energy block
// no dependencies; taken in by files that carry assertions
`ifndef RBM_FREE_ENERGY_MACROS_SVH
`define RBM_FREE_ENERGY_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RBMFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define RBMFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/rbmfe_pkg.sv -----
// rbmfe_pkg: types, constants and the softplus correction table
// no dependencies
`timescale 1ns / 1ps

package rbmfe_pkg;

	localparam int AccW = 23;   // hidden field, signed Q.12
	localparam int SpW  = 23;   // softplus of one field, unsigned
	localparam int TotW = 29;   // running sum of softplus
	localparam int OutW = 28;
	localparam int CorrLen = 36;

	localparam logic [TotW-1:0] OUT_LIMIT = TotW'(134217728);

	// operation codes carried on func
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_FE   = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_FIN
	} fe_state_t;

	typedef struct packed {
		logic clr;
		logic en;
	} cell_ctrl_t;

	// round(4096 * ln(1 + exp(-(2k+1)/8)))
	function automatic logic [11:0] sp_corr(input logic [5:0] k);
		logic [11:0] v;
		case (k)
			6'd0: v = 12'd2591;   6'd1: v = 12'd2143;   6'd2: v = 12'd1756;
			6'd3: v = 12'd1427;   6'd4: v = 12'd1152;   6'd5: v = 12'd923;
			6'd6: v = 12'd736;    6'd7: v = 12'd584;    6'd8: v = 12'd462;
			6'd9: v = 12'd364;    6'd10: v = 12'd286;   6'd11: v = 12'd225;
			6'd12: v = 12'd176;   6'd13: v = 12'd138;   6'd14: v = 12'd108;
			6'd15: v = 12'd84;    6'd16: v = 12'd66;    6'd17: v = 12'd51;
			6'd18: v = 12'd40;    6'd19: v = 12'd31;    6'd20: v = 12'd24;
			6'd21: v = 12'd19;    6'd22: v = 12'd15;    6'd23: v = 12'd11;
			6'd24: v = 12'd9;     6'd25: v = 12'd7;     6'd26: v = 12'd5;
			6'd27: v = 12'd4;     6'd28: v = 12'd3;     6'd29: v = 12'd3;
			6'd30: v = 12'd2;     6'd31: v = 12'd2;     6'd32: v = 12'd1;
			6'd33: v = 12'd1;     6'd34: v = 12'd1;     6'd35: v = 12'd1;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/rbm_free_energy.sv -----
// rbm_free_energy: top level of the restricted Boltzmann machine free-energy block
// depends on rbmfe_pkg, rbmfe_cell, rbmfe_softplus and rbm_free_energy_macros.svh
`timescale 1ns / 1ps
`include "rbm_free_energy_macros.svh"

// A load transfer (func = 0) writes one Q4.12 weight into the on-chip weight memory;
// loads to an out-of-range row or column are dropped. A compute transfer (func = 1)
// reads every weight once, one per cycle from the single memory read port, before
// the result is presented. The hidden fields live in a ring of HIDDEN_UNITS cells
// that rotates one place per weight read; the head cell adds the weight when its
// visible bit is set. Once all rows are in, the ring is shifted out through the
// softplus unit and summed, then negated and clamped at -2^27. The result sits in
// an output register, so new transfers are taken while it waits. The weight memory
// has no reset: weights must be loaded before use.
module rbm_free_energy #(
	parameter int VISIBLE_UNITS = 64,
	parameter int HIDDEN_UNITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [5:0]                          visible_row,
	input  logic [4:0]                          hidden_col,
	input  logic signed [15:0]                  weight_value,
	input  logic [63:0]                         visible_bits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rbmfe_pkg::OutW-1:0]   free_energy,
	output logic                                saturated
);

	localparam int RW    = $clog2(VISIBLE_UNITS);
	localparam int CW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int DEPTH = 1 << (RW + CW);
	localparam int DW    = $clog2(HIDDEN_UNITS + 2);
	localparam int AW    = rbmfe_pkg::AccW;

	// state and control
	rbmfe_pkg::fe_state_t state_q, state_d;
	logic [RW-1:0] ri_q;
	logic [CW-1:0] ci_q;
	logic [DW-1:0] dcnt_q;
	logic [VISIBLE_UNITS-1:0] bits_q;
	logic last_rd;
	logic acc_start, ld_fire, out_load;

	// weight memory
	logic signed [15:0] mem [DEPTH];
	logic [6:0] rowx, colx;
	logic [RW+CW-1:0] wr_addr;
	logic signed [15:0] rd_s1;
	logic rdv_s1, bit_s1;

	// cell ring
	logic signed [AW-1:0] acc [HIDDEN_UNITS];
	logic signed [AW-1:0] head_add;
	rbmfe_pkg::cell_ctrl_t cctl;
	logic drain_shift;

	// softplus and sum
	logic [rbmfe_pkg::SpW-1:0] sp_c, sp_s1;
	logic spv_s1;
	logic [rbmfe_pkg::TotW-1:0] total_q;
	logic out_valid_q, sat_q;
	logic signed [rbmfe_pkg::OutW-1:0] fe_q;

	assign in_ready  = (state_q == rbmfe_pkg::S_IDLE);
	assign acc_start = in_valid && in_ready && (func == rbmfe_pkg::FUNC_FE);
	assign ld_fire   = in_valid && in_ready && (func == rbmfe_pkg::FUNC_LOAD);
	assign last_rd   = (ri_q == RW'(VISIBLE_UNITS - 1)) && (ci_q == CW'(HIDDEN_UNITS - 1));

	// next state
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			rbmfe_pkg::S_IDLE: begin
				if (acc_start) state_d = rbmfe_pkg::S_RUN;
			end
			rbmfe_pkg::S_RUN: begin
				if (last_rd) state_d = rbmfe_pkg::S_DRAIN;
			end
			rbmfe_pkg::S_DRAIN: begin
				if (dcnt_q == DW'(HIDDEN_UNITS + 1)) state_d = rbmfe_pkg::S_FIN;
			end
			rbmfe_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = rbmfe_pkg::S_IDLE;
				end
			end
			default: state_d = rbmfe_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbmfe_pkg::S_IDLE;
			ri_q    <= '0;
			ci_q    <= '0;
			dcnt_q  <= '0;
			rdv_s1  <= 1'b0;
			spv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= (state_q == rbmfe_pkg::S_RUN);
			spv_s1  <= drain_shift;
			if (acc_start) begin
				ri_q   <= '0;
				ci_q   <= '0;
				dcnt_q <= '0;
			end else if (state_q == rbmfe_pkg::S_RUN) begin
				// column inner, row outer
				if (ci_q == CW'(HIDDEN_UNITS - 1)) begin
					ci_q <= '0;
					ri_q <= ri_q + 1'b1;
				end else begin
					ci_q <= ci_q + 1'b1;
				end
			end else if (state_q == rbmfe_pkg::S_DRAIN) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	// visible vector latched on a compute transfer
	always_ff @(posedge clk) begin
		if (acc_start) bits_q <= visible_bits[VISIBLE_UNITS-1:0];
	end

	// weight memory: write on load, one read per cycle while running
	assign rowx    = 7'(visible_row);
	assign colx    = 7'(hidden_col);
	assign wr_addr = {rowx[RW-1:0], colx[CW-1:0]};

	always_ff @(posedge clk) begin
		if (ld_fire && (rowx < 7'(VISIBLE_UNITS)) && (colx < 7'(HIDDEN_UNITS))) begin
			mem[wr_addr] <= weight_value;
		end
		rd_s1  <= mem[{ri_q, ci_q}];
		bit_s1 <= bits_q[ri_q];
	end

	// ring of accumulator cells; head adds the weight of an active row
	assign head_add    = (rdv_s1 && bit_s1) ? AW'(rd_s1) : '0;
	assign drain_shift = (state_q == rbmfe_pkg::S_DRAIN) && (dcnt_q != '0) &&
		(dcnt_q <= DW'(HIDDEN_UNITS));
	assign cctl.clr    = acc_start;
	assign cctl.en     = rdv_s1 || drain_shift;

	for (genvar k = 0; k < HIDDEN_UNITS; k++) begin : g_cell
		rbmfe_cell u_cell (
			.clk    (clk),
			.ctrl   (cctl),
			.d_in   ((k == 0) ? acc[HIDDEN_UNITS-1] : acc[(k == 0) ? 0 : k - 1]),
			.addend ((k == 0) ? head_add : AW'(0)),
			.acc    (acc[k])
		);
	end

	// softplus of the tail cell, then sum
	rbmfe_softplus u_sp (
		.h  (acc[HIDDEN_UNITS-1]),
		.sp (sp_c)
	);

	always_ff @(posedge clk) begin
		sp_s1 <= sp_c;
		if (acc_start) begin
			total_q <= '0;
		end else if (spv_s1) begin
			total_q <= total_q + rbmfe_pkg::TotW'(sp_s1);
		end
	end

	// output register: negate and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (total_q > rbmfe_pkg::OUT_LIMIT) begin
				fe_q  <= rbmfe_pkg::OutW'(rbmfe_pkg::OUT_LIMIT);
				sat_q <= 1'b1;
			end else begin
				fe_q  <= rbmfe_pkg::OutW'(~total_q + 1'b1);
				sat_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign free_energy = fe_q;
	assign saturated   = sat_q;

	`RBMFE_ASSERT_IMPL(a_sat_clamp, clk, arst_n, out_valid && saturated,
		free_energy == rbmfe_pkg::OutW'(rbmfe_pkg::OUT_LIMIT))
	`RBMFE_ASSERT_IMPL(a_fe_nonpos, clk, arst_n, out_valid,
		free_energy[rbmfe_pkg::OutW-1] || (free_energy == '0))
	`RBMFE_ASSERT_NEXT(a_sp_in_drain, clk, arst_n, drain_shift,
		spv_s1 && ($past(state_q) == rbmfe_pkg::S_DRAIN))
	`RBMFE_ASSERT_NEXT(a_fin_presents, clk, arst_n,
		(state_q == rbmfe_pkg::S_FIN) && (!out_valid_q || out_ready), out_valid_q)

endmodule

// ----- design/rbmfe_cell.sv -----
// rbmfe_cell: one accumulator cell of the hidden-field ring
// depends on rbmfe_pkg
`timescale 1ns / 1ps

module rbmfe_cell (
	input  logic                                clk,
	input  rbmfe_pkg::cell_ctrl_t               ctrl,
	input  logic signed [rbmfe_pkg::AccW-1:0]   d_in,
	input  logic signed [rbmfe_pkg::AccW-1:0]   addend,
	output logic signed [rbmfe_pkg::AccW-1:0]   acc
);

	logic signed [rbmfe_pkg::AccW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= d_in + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/rbmfe_softplus.sv -----
// rbmfe_softplus: softplus of one hidden field in Q.12
// depends on rbmfe_pkg
`timescale 1ns / 1ps

module rbmfe_softplus (
	input  logic signed [rbmfe_pkg::AccW-1:0] h,
	output logic [rbmfe_pkg::SpW-1:0]         sp
);

	logic [rbmfe_pkg::AccW-1:0] mag;
	logic [rbmfe_pkg::AccW-11:0] idx;
	logic [11:0] corr;
	logic [rbmfe_pkg::SpW-1:0] pos;

	always_comb begin
		mag  = h[rbmfe_pkg::AccW-1] ? (~h + 1'b1) : h;
		idx  = mag[rbmfe_pkg::AccW-1:10];
		corr = (idx < (rbmfe_pkg::AccW-10)'(rbmfe_pkg::CorrLen)) ?
			rbmfe_pkg::sp_corr(idx[5:0]) : 12'd0;
		pos  = h[rbmfe_pkg::AccW-1] ? '0 : rbmfe_pkg::SpW'(h);
		sp   = pos + rbmfe_pkg::SpW'(corr);
	end

endmodule
